// ===== rtl/core/irlas_pkg.sv =====
// ----------------------------------------------------------------------------
// irlas_pkg
// Shared types, constants and tables for the IR light auto switch.
// ----------------------------------------------------------------------------
package irlas_pkg;

  // Field widths
  localparam int SAMPLE_W   = 12;
  localparam int LEVEL_W    = 8;
  localparam int MODE_W     = 3;
  localparam int CMD_W      = 2;
  localparam int RUN_W      = 3;
  localparam int THRESH_W   = SAMPLE_W + 1;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;

  // Defaults for the top-level parameters
  localparam int WINDOW_LEN_DEF    = 5;
  localparam int PERSIST_TICKS_DEF = 5;

  // Reciprocal table for the window average: floor(2^RECIP_SHIFT / n)
  localparam int WINDOW_MAX  = 8;
  localparam int RECIP_SHIFT = 16;
  localparam int RECIP_W     = RECIP_SHIFT + 1;
  localparam int RECIP_IDX_W = $clog2(WINDOW_MAX + 1);

  localparam logic [RECIP_W-1:0] RECIP_TABLE [0:WINDOW_MAX] = '{
    17'd0,     17'd65536, 17'd32768, 17'd21845, 17'd16384,
    17'd13107, 17'd10922, 17'd9362,  17'd8192
  };

  // Mode codes
  localparam logic [MODE_W-1:0] MODE_FORCE_OFF = 3'd0;
  localparam logic [MODE_W-1:0] MODE_FORCE_ON  = 3'd5;

  // Register reset values
  localparam logic [SAMPLE_W-1:0] TARGET_RESET = 12'd2;
  localparam logic [LEVEL_W-1:0]  MARGIN_RESET = 8'd15;

  // Light commands
  typedef enum logic [CMD_W-1:0] {
    CMD_NONE = 2'd0,
    CMD_ON   = 2'd1,
    CMD_OFF  = 2'd2
  } light_cmd_t;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE   = 3'd0,
    REG_CHECK  = 3'd1,
    REG_DRIVE  = 3'd2,
    REG_TARGET = 3'd3,
    REG_MARGIN = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [MODE_W-1:0]   mode;
    logic                check_enable;
    logic [LEVEL_W-1:0]  drive_level;
    logic [SAMPLE_W-1:0] target_level;
    logic [LEVEL_W-1:0]  off_margin;
  } cfg_t;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_CORR,
    ST_EMIT
  } ctrl_state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic mul;
    logic corr;
    logic emit;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic auto_mode;
    logic out_free;
  } dp_status_t;

endpackage

// ===== rtl/core/irlas_regs.sv =====
// ----------------------------------------------------------------------------
// irlas_regs
// Configuration register file, written through the cfg request channel.
// ----------------------------------------------------------------------------
module irlas_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [irlas_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [irlas_pkg::CFG_DATA_W-1:0] cfg_data,
  output irlas_pkg::cfg_t              cfg
);
  import irlas_pkg::*;

  // Writes are always taken
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode         <= MODE_FORCE_OFF;
      cfg.check_enable <= 1'b0;
      cfg.drive_level  <= '0;
      cfg.target_level <= TARGET_RESET;
      cfg.off_margin   <= MARGIN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (reg_idx_t'(cfg_index))
        REG_MODE:   cfg.mode         <= cfg_data[MODE_W-1:0];
        REG_CHECK:  cfg.check_enable <= cfg_data[0];
        REG_DRIVE:  cfg.drive_level  <= cfg_data[LEVEL_W-1:0];
        REG_TARGET: cfg.target_level <= cfg_data[SAMPLE_W-1:0];
        REG_MARGIN: cfg.off_margin   <= cfg_data[LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/core/irlas_ctrl.sv =====
// ----------------------------------------------------------------------------
// irlas_ctrl
// Sequencer: accept, reciprocal multiply and correction in automatic mode, result hand-off.
// ----------------------------------------------------------------------------
module irlas_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  irlas_pkg::dp_status_t status,
  output irlas_pkg::dp_cmd_t    cmd
);
  import irlas_pkg::*;

  ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and datapath commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = status.auto_mode ? ST_MUL : ST_EMIT;
        end
      end
      ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = ST_CORR;
      end
      ST_CORR: begin
        cmd.corr   = 1'b1;
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

// ===== rtl/core/irlas_dp.sv =====
// ----------------------------------------------------------------------------
// irlas_dp
// Sample window, windowed average by reciprocal multiply, run counters and
// the output register.
// ----------------------------------------------------------------------------
module irlas_dp #(
  parameter int WINDOW_LEN    = irlas_pkg::WINDOW_LEN_DEF,
  parameter int PERSIST_TICKS = irlas_pkg::PERSIST_TICKS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  irlas_pkg::cfg_t                 cfg,
  input  irlas_pkg::dp_cmd_t              cmd,
  output irlas_pkg::dp_status_t           status,
  input  logic [irlas_pkg::SAMPLE_W-1:0]  light_sample,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [irlas_pkg::CMD_W-1:0]     light_command,
  output logic [irlas_pkg::LEVEL_W-1:0]   light_level,
  output logic [irlas_pkg::SAMPLE_W-1:0]  average_level
);
  import irlas_pkg::*;

  localparam int FILL_W = $clog2(WINDOW_LEN + 1);
  localparam int SUM_W  = SAMPLE_W + $clog2(WINDOW_LEN);
  localparam int PROD_W = SUM_W + RECIP_W;
  localparam int REM_W  = SUM_W + FILL_W;
  localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(WINDOW_LEN);
  localparam logic [RUN_W-1:0]  RUN_MAX   = '1;
  localparam logic [RUN_W-1:0]  PERSIST   = RUN_W'(PERSIST_TICKS);

  logic [SAMPLE_W-1:0] win [WINDOW_LEN];
  logic [FILL_W-1:0]   fill;
  logic [RUN_W-1:0]    dark_run;
  logic [RUN_W-1:0]    bright_run;
  logic [SAMPLE_W-1:0] last_average;
  logic [SUM_W-1:0]    sum_q;
  logic [PROD_W-1:0]   prod_q;
  light_cmd_t          cmd_q;
  logic [LEVEL_W-1:0]  level_q;

  logic                forced_off;
  logic                forced_on;
  logic [SUM_W-1:0]    sum_next;
  logic [SUM_W-1:0]    quot0;
  logic [REM_W-1:0]    rem;
  logic [SUM_W-1:0]    quot;
  logic [SAMPLE_W-1:0] avg;
  logic [THRESH_W-1:0] thresh;
  logic [RUN_W-1:0]    dark_next;
  logic [RUN_W-1:0]    bright_next;

  // Mode decode; codes above forced-on act as forced-on
  assign forced_off       = (cfg.mode == MODE_FORCE_OFF);
  assign forced_on        = (cfg.mode >= MODE_FORCE_ON);
  assign status.auto_mode = cfg.check_enable && !forced_off && !forced_on;
  assign status.out_free  = !out_valid || !out_stall;

  // Sum of the window after the new sample shifts in
  always_comb begin
    sum_next = SUM_W'(light_sample);
    for (int i = 1; i < WINDOW_LEN; i++) begin
      sum_next = sum_next + SUM_W'(win[i]);
    end
  end

  // Quotient estimate is exact or one low; one compare fixes it
  always_comb begin
    quot0 = prod_q[RECIP_SHIFT +: SUM_W];
    rem   = REM_W'(sum_q) - REM_W'(quot0) * REM_W'(fill);
    quot  = (rem >= REM_W'(fill)) ? quot0 + SUM_W'(1) : quot0;
    avg   = quot[SAMPLE_W-1:0];
  end

  // Run counters with saturation
  always_comb begin
    thresh      = THRESH_W'(cfg.target_level) + THRESH_W'(cfg.off_margin);
    dark_next   = '0;
    bright_next = '0;
    if (avg < cfg.target_level) begin
      dark_next = (dark_run == RUN_MAX) ? dark_run : dark_run + RUN_W'(1);
    end
    if (THRESH_W'(avg) > thresh) begin
      bright_next = (bright_run == RUN_MAX) ? bright_run : bright_run + RUN_W'(1);
    end
  end

  // Tracking state
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < WINDOW_LEN; i++) win[i] <= '0;
      fill         <= '0;
      dark_run     <= '0;
      bright_run   <= '0;
      last_average <= '0;
    end else if (cmd.load && cfg.check_enable) begin
      if (status.auto_mode) begin
        for (int i = 0; i < WINDOW_LEN - 1; i++) win[i] <= win[i+1];
        win[WINDOW_LEN-1] <= light_sample;
        if (fill != FILL_FULL) fill <= fill + FILL_W'(1);
      end else begin
        for (int i = 0; i < WINDOW_LEN; i++) win[i] <= '0;
        fill       <= '0;
        dark_run   <= '0;
        bright_run <= '0;
      end
    end else if (cmd.corr) begin
      last_average <= avg;
      dark_run     <= (dark_next >= PERSIST) ? '0 : dark_next;
      bright_run   <= (bright_next >= PERSIST) ? '0 : bright_next;
    end
  end

  // Arithmetic pipeline and pending result
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sum_q <= sum_next;
      if (cfg.check_enable && forced_off) begin
        cmd_q   <= CMD_OFF;
        level_q <= '0;
      end else if (cfg.check_enable && forced_on) begin
        cmd_q   <= CMD_ON;
        level_q <= cfg.drive_level;
      end else begin
        cmd_q   <= CMD_NONE;
        level_q <= '0;
      end
    end else if (cmd.mul) begin
      prod_q <= PROD_W'(sum_q) * PROD_W'(RECIP_TABLE[RECIP_IDX_W'(fill)]);
    end else if (cmd.corr) begin
      // the two runs exclude each other
      if (bright_next >= PERSIST) begin
        cmd_q   <= CMD_OFF;
        level_q <= '0;
      end else if (dark_next >= PERSIST) begin
        cmd_q   <= CMD_ON;
        level_q <= cfg.drive_level;
      end else begin
        cmd_q   <= CMD_NONE;
        level_q <= '0;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      light_command <= cmd_q;
      light_level   <= level_q;
      average_level <= last_average;
    end
  end

endmodule

// ===== rtl/core/ir_light_auto_switch.sv =====
// ----------------------------------------------------------------------------
// ir_light_auto_switch
// Moving-average hysteresis switch for an IR light: averages the last
// samples and commands the light on or off after a persistent run.
//
//   channel  | handshake             | payload
//   ---------+-----------------------+-------------------------------------
//   in       | in_valid / in_stall   | light_sample
//   out      | out_valid / out_stall | light_command, light_level,
//            |                       | average_level
//   cfg      | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// Automatic mode handles a request as: accept with window update and
// sum, reciprocal multiply, quotient correction, hand-off to the output
// register. Disabled and forced modes go straight from accept to hand-off.
// One request is in flight at a time. Synchronous reset clears the window,
// counters and output valid flag, and sets the configuration registers to
// defaults. A stalled output holds its result; a new request may be accepted
// while it waits, and the next hand-off waits for the output register to free.
// ----------------------------------------------------------------------------
module ir_light_auto_switch #(
  parameter int WINDOW_LEN    = irlas_pkg::WINDOW_LEN_DEF,
  parameter int PERSIST_TICKS = irlas_pkg::PERSIST_TICKS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [irlas_pkg::SAMPLE_W-1:0]   light_sample,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [irlas_pkg::CMD_W-1:0]      light_command,
  output logic [irlas_pkg::LEVEL_W-1:0]    light_level,
  output logic [irlas_pkg::SAMPLE_W-1:0]   average_level,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [irlas_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [irlas_pkg::CFG_DATA_W-1:0] cfg_data
);
  import irlas_pkg::*;

  cfg_t       cfg;
  dp_cmd_t    cmd;
  dp_status_t status;

  irlas_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  irlas_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  irlas_dp #(
    .WINDOW_LEN    (WINDOW_LEN),
    .PERSIST_TICKS (PERSIST_TICKS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .cmd           (cmd),
    .status        (status),
    .light_sample  (light_sample),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .light_command (light_command),
    .light_level   (light_level),
    .average_level (average_level)
  );

endmodule

// ===== rtl/core/irlas_checker.sv =====
// ----------------------------------------------------------------------------
// irlas_checker
// Port-level checks for the IR light auto switch, bound to the top level.
// ----------------------------------------------------------------------------
module irlas_port_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            in_valid,
  input logic                            in_stall,
  input logic                            out_valid,
  input logic                            out_stall,
  input logic [irlas_pkg::CMD_W-1:0]     light_command,
  input logic [irlas_pkg::LEVEL_W-1:0]   light_level,
  input logic [irlas_pkg::SAMPLE_W-1:0]  average_level
);
  import irlas_pkg::*;

  // One request in flight: input closes right after an accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted on back-to-back cycles");

  // Only defined command codes leave the block
  a_cmd_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (light_command == CMD_NONE || light_command == CMD_ON ||
                   light_command == CMD_OFF))
    else $error("undefined light command");

  // Drive level only accompanies a switch-on
  a_level_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && light_command != CMD_ON) |-> (light_level == '0))
    else $error("nonzero level without switch-on");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(light_command) &&
                                  $stable(light_level) && $stable(average_level)))
    else $error("stalled result changed");

endmodule

bind ir_light_auto_switch irlas_port_checker u_irlas_port_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .light_command (light_command),
  .light_level   (light_level),
  .average_level (average_level)
);
